// ===== rtl/binary_perceptron_trainer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the perceptron trainer checkers.
// ----------------------------------------------------------------------------
`ifndef BINARY_PERCEPTRON_TRAINER_MACROS_SVH
`define BINARY_PERCEPTRON_TRAINER_MACROS_SVH

// check consequent in the cycle after the antecedent
`define BPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpt assertion failed");

// check consequent in the same cycle as the antecedent
`define BPT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpt assertion failed");

`endif

// ===== rtl/bpt_pkg.sv =====
// ----------------------------------------------------------------------------
// bpt_pkg
// Widths, constants and types of the binary perceptron trainer.
// ----------------------------------------------------------------------------
package bpt_pkg;

    localparam int GRID_SIDE        = 8;
    localparam int LABEL_COUNT      = 16;
    localparam int WEIGHT_FRAC_BITS = 8;

    localparam int PIXELS      = GRID_SIDE * GRID_SIDE;
    localparam int IMAGE_W     = 64;
    localparam int LABEL_W     = 6;
    localparam int PENALTY_W   = 8;
    localparam int WEIGHT_W    = 16;
    localparam int DELTA_W     = WEIGHT_W + 1;
    localparam int SUM_W       = WEIGHT_W + $clog2(PIXELS) + 1;
    localparam int CNT_W       = $clog2(PIXELS);

    localparam int IN_TDATA_W  = ((IMAGE_W + LABEL_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 8;

    localparam int PENALTY_RAW   = (1 << WEIGHT_FRAC_BITS) / LABEL_COUNT;
    localparam int PENALTY_RESET = (PENALTY_RAW > 255) ? 255 : PENALTY_RAW;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LABEL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PENALTY_STEP = CFG_IDX_W'(1);

    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic signed [DELTA_W-1:0]  delta_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    localparam delta_t WEIGHT_ONE = delta_t'(1 << WEIGHT_FRAC_BITS);

    typedef struct packed {
        logic   upd_en;
        delta_t delta;
    } cell_ctrl_t;

endpackage

// ===== rtl/bpt_cell.sv =====
// ----------------------------------------------------------------------------
// bpt_cell
// One pixel cell: holds a weight, adds it to the running sum from its
// neighbor when its pixel bit is set, and applies the saturating update when told to and its pixel bit is set.
// ----------------------------------------------------------------------------
module bpt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pix_bit,
    input  bpt_pkg::sum_t       sum_in,
    input  bpt_pkg::cell_ctrl_t ctrl,
    output bpt_pkg::sum_t       sum_out
);
    import bpt_pkg::*;

    weight_t                   w_reg;
    weight_t                   w_next;
    sum_t                      sum_reg;
    sum_t                      sum_next;
    logic signed [WEIGHT_W+1:0] upd_sum;

    always_comb
    begin
        upd_sum = (WEIGHT_W + 2)'(w_reg) + (WEIGHT_W + 2)'(ctrl.delta);
        w_next  = w_reg;
        if (ctrl.upd_en && pix_bit)
        begin
            if (upd_sum[WEIGHT_W+1:WEIGHT_W-1] == 3'b000 ||
                upd_sum[WEIGHT_W+1:WEIGHT_W-1] == 3'b111)
            begin
                w_next = upd_sum[WEIGHT_W-1:0];
            end
            else if (upd_sum[WEIGHT_W+1])
            begin
                w_next = {1'b1, {(WEIGHT_W-1){1'b0}}};
            end
            else
            begin
                w_next = {1'b0, {(WEIGHT_W-1){1'b1}}};
            end
        end
        sum_next = pix_bit ? (sum_in + sum_t'(w_reg)) : sum_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg <= '0;
        end
        else
        begin
            w_reg <= w_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    assign sum_out = sum_reg;

endmodule

// ===== rtl/binary_perceptron_trainer.sv =====
// ----------------------------------------------------------------------------
// binary_perceptron_trainer
// Single perceptron neuron trained on binary images with a row of weight cells.
//
//   channel  | dir | handshake              | payload
//   s_*      | in  | s_tvalid / s_tready    | image_bits, shown_label
//   m_*      | out | m_tvalid / m_tready    | fires, correct
//   cfg_*    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An item passes through the accept cycle, the weighted sum moving through the
// registered chain one cell per cycle, then the update cycle; m_tvalid rises
// from a register that is set in the update cycle.
// Reset clears all weights, sets target_label to 0 and penalty_step to 16.
// A result held by m_tready low delays the update cycle; the next image is taken
// as soon as the update is done, while the result may still wait.
// ----------------------------------------------------------------------------
module binary_perceptron_trainer (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bpt_pkg::IN_TDATA_W-1:0]     s_tdata,   // image_bits, shown_label
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bpt_pkg::OUT_TDATA_W-1:0]    m_tdata,   // fires, correct
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpt_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bpt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SUM  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [PIXELS-1:0]    bits_reg;
    logic [LABEL_W-1:0]   label_reg;
    logic [LABEL_W-1:0]   target_reg;
    logic [PENALTY_W-1:0] penalty_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 fires_reg;
    logic                 correct_reg;
    logic                 in_beat;
    logic                 out_free;
    logic                 do_update;
    logic                 fires;
    logic                 correct;
    cell_ctrl_t           ctrl;
    sum_t                 chain [PIXELS];

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign do_update = (state_reg == ST_UPD) && out_free;

    assign fires   = chain[PIXELS-1] > 0;
    assign correct = fires == (label_reg == target_reg);

    assign ctrl.upd_en = do_update && !correct;
    assign ctrl.delta  = fires ? -delta_t'({1'b0, penalty_reg}) : WEIGHT_ONE;

    genvar gi;
    generate
        for (gi = 0; gi < PIXELS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                bpt_cell u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .pix_bit (bits_reg[gi]),
                    .sum_in  ('0),
                    .ctrl    (ctrl),
                    .sum_out (chain[gi])
                );
            end
            else
            begin : g_body
                bpt_cell u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .pix_bit (bits_reg[gi]),
                    .sum_in  (chain[gi-1]),
                    .ctrl    (ctrl),
                    .sum_out (chain[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_SUM;
                    cnt_next   = '0;
                end
            end
            ST_SUM:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(PIXELS - 1))
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (out_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            target_reg    <= '0;
            penalty_reg   <= PENALTY_W'(PENALTY_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_TARGET_LABEL)
                begin
                    target_reg <= cfg_data[LABEL_W-1:0];
                end
                else if (cfg_index == REG_PENALTY_STEP)
                begin
                    penalty_reg <= cfg_data[PENALTY_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            bits_reg  <= s_tdata[PIXELS-1:0];
            label_reg <= s_tdata[IMAGE_W +: LABEL_W];
        end
        if (do_update)
        begin
            fires_reg   <= fires;
            correct_reg <= correct;
        end
    end

    assign s_tready  = state_reg == ST_IDLE;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_TDATA_W'({correct_reg, fires_reg});
    assign cfg_ready = 1'b1;

endmodule

// ===== rtl/bpt_checker.sv =====
// ----------------------------------------------------------------------------
// bpt_checker
// Port-level checks of the perceptron trainer, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_perceptron_trainer_macros.svh"

module bpt_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [bpt_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [bpt_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready
);
    import bpt_pkg::*;

    logic in_beat;
    logic in_stall;
    logic out_stall;

    assign in_beat   = s_tvalid && s_tready;
    assign in_stall  = s_tvalid && !s_tready;
    assign out_stall = m_tvalid && !m_tready;

    `BPT_ASSERT_NEXT(a_out_held, out_stall, m_tvalid && $stable(m_tdata))
    `BPT_ASSERT_NEXT(a_in_held, in_stall, s_tvalid && $stable(s_tdata))
    `BPT_ASSERT_NEXT(a_busy_after_beat, in_beat, !s_tready)
    `BPT_ASSERT_SAME(a_result_frees_input, $rose(m_tvalid), $rose(s_tready))
    `BPT_ASSERT_SAME(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind binary_perceptron_trainer bpt_checker u_bpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
